// File: hdl/scancode_to_ascii_keyboard_fifo_defines.svh
// Assertion macros used by the keyboard buffer top level.
`ifndef SCANCODE_TO_ASCII_KEYBOARD_FIFO_DEFINES_SVH
`define SCANCODE_TO_ASCII_KEYBOARD_FIFO_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset
`define SC2A_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sc2a assertion failed");
// Check that a condition never holds outside reset
`define SC2A_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("sc2a forbidden condition seen");
`else
`define SC2A_ASSERT(label, clk, rst, prop)
`define SC2A_NEVER(label, clk, rst, cond)
`endif

`endif

// File: hdl/sc2a_pkg.sv
// Types, constants and key tables of the scancode to ASCII keyboard buffer.
package sc2a_pkg;

   // Character buffer geometry
   localparam int FIFO_DEPTH = 256;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   // Register file
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_ARROW_UP    = 2'd0;
   localparam logic [1:0] REG_ARROW_DOWN  = 2'd1;
   localparam logic [1:0] REG_ARROW_LEFT  = 2'd2;
   localparam logic [1:0] REG_ARROW_RIGHT = 2'd3;

   // Operations
   localparam logic [1:0] OP_SCAN  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Set-1 key codes
   localparam logic [6:0] KC_LSHIFT = 7'h2A;
   localparam logic [6:0] KC_RSHIFT = 7'h36;
   localparam logic [6:0] KC_LCTRL  = 7'h1D;
   localparam logic [6:0] KC_CAPS   = 7'h3A;
   localparam logic [6:0] KC_UP     = 7'h48;
   localparam logic [6:0] KC_DOWN   = 7'h50;
   localparam logic [6:0] KC_LEFT   = 7'h4B;
   localparam logic [6:0] KC_RIGHT  = 7'h4D;
   localparam logic [6:0] MAP_LIMIT = 7'd58;
   localparam logic [6:0] CAPS_LO   = 7'h10;
   localparam logic [6:0] CAPS_HI   = 7'h32;

   localparam int MAP_N = 58;

   localparam logic [7:0] PLAIN_MAP [MAP_N] = '{
      8'h00, 8'h1B, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'h08,
      8'h09, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'h0A,
      8'h00, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'h27, 8'h60,
      8'h00, 8'h5C, "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'h00,
      "*", 8'h00, " "
   };

   localparam logic [7:0] SHIFTED_MAP [MAP_N] = '{
      8'h00, 8'h1B, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'h08,
      8'h09, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'h0A,
      8'h00, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h22, "~",
      8'h00, "|", "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'h00,
      "*", 8'h00, " "
   };

   // Channel words
   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] scan_code;
   } req_word_type;

   typedef struct packed {
      logic [7:0] read_char;
      logic       has_char;
      logic       shift_held;
      logic       ctrl_held;
   } rsp_word_type;

   // Modifier state
   typedef struct packed {
      logic shift;
      logic ctrl;
      logic caps;
   } mod_flags_type;

   typedef struct packed {
      logic [7:0] up;
      logic [7:0] down;
      logic [7:0] left;
      logic [7:0] right;
   } arrow_codes_type;

   // Decoder verdict for one scancode
   typedef struct packed {
      mod_flags_type flags;
      logic          push;
      logic [7:0]    push_char;
   } decode_type;

endpackage

// File: hdl/sc2a_decode.sv
// Scancode decoder: modifier tracking, arrow keys and character lookup.
module sc2a_decode (
   input  logic [7:0]               scan_code,
   input  sc2a_pkg::mod_flags_type   flags,
   input  sc2a_pkg::arrow_codes_type arrows,
   output sc2a_pkg::decode_type      verdict
);
   import sc2a_pkg::*;

   logic       released;
   logic [6:0] key;
   logic       upper;
   logic [5:0] map_idx;
   logic [7:0] map_char;

   assign released = scan_code[7];
   assign key      = scan_code[6:0];

   // Pick the table; caps lock flips shift on the letter rows
   always_comb begin
      upper   = flags.shift ^ (flags.caps && key >= CAPS_LO && key <= CAPS_HI);
      map_idx = (key < MAP_LIMIT) ? key[5:0] : '0;
      map_char = upper ? SHIFTED_MAP[map_idx] : PLAIN_MAP[map_idx];
   end

   // Update modifiers or produce a character
   always_comb begin
      verdict.flags     = flags;
      verdict.push      = 1'b0;
      verdict.push_char = '0;
      if (key == KC_LSHIFT || key == KC_RSHIFT) begin
         verdict.flags.shift = !released;
      end else if (key == KC_LCTRL) begin
         verdict.flags.ctrl = !released;
      end else if (key == KC_CAPS) begin
         if (!released) begin
            verdict.flags.caps = !flags.caps;
         end
      end else if (!released) begin
         if (key == KC_UP) begin
            verdict.push      = 1'b1;
            verdict.push_char = arrows.up;
         end else if (key == KC_DOWN) begin
            verdict.push      = 1'b1;
            verdict.push_char = arrows.down;
         end else if (key == KC_LEFT) begin
            verdict.push      = 1'b1;
            verdict.push_char = arrows.left;
         end else if (key == KC_RIGHT) begin
            verdict.push      = 1'b1;
            verdict.push_char = arrows.right;
         end else if (key < MAP_LIMIT) begin
            verdict.push      = (map_char != 8'h00);
            verdict.push_char = map_char;
         end
      end
   end

endmodule

// File: hdl/scancode_to_ascii_keyboard_fifo.sv
// Top level: input stage, decoder, character ring buffer and register file.
//
//   channel  | direction | handshake              | word
//   req      | in        | req_valid / req_ready  | operation, scan_code
//   rsp      | out       | rsp_valid / rsp_ready  | read_char, has_char, shift_held, ctrl_held
//   csr      | in/out    | psel, penable, pready  | four arrow key codes, 8 bits each
//
// One word a cycle is sustained while results are taken; a word passes from acceptance
// to result through the input register and then the result register, the buffer read data
// register sitting beside the latter. Reset clears pointers and modifiers and loads the
// arrow codes with 128 to 131; the buffer storage is not cleared. A stalled result holds
// the input stage, which holds req_ready low only while both stages are full.
`include "scancode_to_ascii_keyboard_fifo_defines.svh"
module scancode_to_ascii_keyboard_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sc2a_pkg::req_word_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sc2a_pkg::rsp_word_type          rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sc2a_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import sc2a_pkg::*;

   // Input stage
   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff;
   logic         advance;

   // Result stage
   logic         out_valid_ff, out_valid_in;
   logic         pop_ff;
   logic         has_char_ff, has_char_in;
   logic [7:0]   rdata_ff;

   // Buffer and modifier state
   logic [7:0]       char_mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
   mod_flags_type    flags_ff, flags_in;
   arrow_codes_type  arrows_ff, arrows_in;

   logic       empty, full, do_push, do_pop, do_clear, is_scan;
   decode_type verdict;
   logic       csr_write;

   // Handshakes
   assign advance     = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || advance;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   sc2a_decode u_decode (
      .scan_code (s1_word_ff.scan_code),
      .flags     (flags_ff),
      .arrows    (arrows_ff),
      .verdict   (verdict)
   );

   // Pointer steps with wrap at the buffer depth
   assign wr_ptr_inc = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_inc = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign empty      = (wr_ptr_ff == rd_ptr_ff);
   assign full       = (wr_ptr_inc == rd_ptr_ff);

   // Work out the effect of the word in the input stage
   always_comb begin
      is_scan   = (s1_word_ff.operation == OP_SCAN);
      do_push   = advance && is_scan && verdict.push && !full;
      do_pop    = advance && (s1_word_ff.operation == OP_READ) && !empty;
      do_clear  = advance && (s1_word_ff.operation == OP_CLEAR);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      flags_in  = flags_ff;
      if (do_clear) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
      end else begin
         if (do_push) begin
            wr_ptr_in = wr_ptr_inc;
         end
         if (do_pop) begin
            rd_ptr_in = rd_ptr_inc;
         end
      end
      if (advance && is_scan) begin
         flags_in = verdict.flags;
      end
      has_char_in = (wr_ptr_in != rd_ptr_in);
   end

   // Register file writes
   assign csr_write = psel && penable && pwrite && pready;
   always_comb begin
      arrows_in = arrows_ff;
      if (csr_write) begin
         unique case (paddr[3:2])
            REG_ARROW_UP:    arrows_in.up    = pwdata[7:0];
            REG_ARROW_DOWN:  arrows_in.down  = pwdata[7:0];
            REG_ARROW_LEFT:  arrows_in.left  = pwdata[7:0];
            REG_ARROW_RIGHT: arrows_in.right = pwdata[7:0];
            default:         arrows_in = arrows_ff;
         endcase
      end
   end

   // Register file reads
   always_comb begin
      unique case (paddr[3:2])
         REG_ARROW_UP:    prdata = {24'd0, arrows_ff.up};
         REG_ARROW_DOWN:  prdata = {24'd0, arrows_ff.down};
         REG_ARROW_LEFT:  prdata = {24'd0, arrows_ff.left};
         REG_ARROW_RIGHT: prdata = {24'd0, arrows_ff.right};
         default:         prdata = '0;
      endcase
   end
   assign pready = 1'b1;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         flags_ff     <= '0;
         arrows_ff    <= '{up: 8'd128, down: 8'd129, left: 8'd130, right: 8'd131};
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         flags_ff     <= flags_in;
         arrows_ff    <= arrows_in;
      end
   end

   // Payload registers: load the input word, hold the result while stalled
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_word_ff <= req_data;
      end
      if (advance) begin
         pop_ff      <= do_pop;
         has_char_ff <= has_char_in;
      end
   end

   // Character buffer: write on push, registered read on pop
   always_ff @(posedge clock) begin
      if (do_push) begin
         char_mem[wr_ptr_ff] <= verdict.push_char;
      end
      if (do_pop) begin
         rdata_ff <= char_mem[rd_ptr_ff];
      end
   end

   // Result word
   assign rsp_valid           = out_valid_ff;
   assign rsp_data.read_char  = pop_ff ? rdata_ff : 8'h00;
   assign rsp_data.has_char   = has_char_ff;
   assign rsp_data.shift_held = flags_ff.shift;
   assign rsp_data.ctrl_held  = flags_ff.ctrl;

   // Checks
   `SC2A_NEVER(a_push_pop_collide, clock, reset, do_push && do_pop && wr_ptr_ff == rd_ptr_ff)
   `SC2A_ASSERT(a_clear_empties, clock, reset, do_clear |=> wr_ptr_ff == rd_ptr_ff)
   `SC2A_ASSERT(a_status_tracks, clock, reset, advance |=> rsp_data.has_char == !empty)
   `SC2A_ASSERT(a_stall_holds_s1, clock, reset, (s1_valid_ff && !advance) |=> s1_valid_ff)

endmodule
